### hw/rtl/segmented_ring_packet_allocator_macros.svh
// Assertion macros used by the checker file.
`ifndef SEGMENTED_RING_PACKET_ALLOCATOR_MACROS_SVH
`define SEGMENTED_RING_PACKET_ALLOCATOR_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SRPA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked during reset.
`define SRPA_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/srpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srpa_pkg;

    localparam int MAX_SEGMENTS     = 16;
    localparam int SEG_BITS         = 4;
    localparam int CNT_BITS         = 5;
    localparam int DESCRIPTOR_DEPTH = 1024;
    localparam int DESC_ADDR_BITS   = $clog2(DESCRIPTOR_DEPTH);
    localparam int OFFSET_BITS      = 24;
    localparam int LEN_BITS         = 24;
    localparam int SIZE_BITS        = 24;
    localparam int TYPE_BITS        = 8;
    localparam int SEQ_BITS         = 32;
    localparam int CFG_DATA_BITS    = 24;

    localparam logic [CNT_BITS-1:0]  SEG_COUNT_RESET = CNT_BITS'(16);
    localparam logic [SIZE_BITS-1:0] SEG_SIZE_RESET  = SIZE_BITS'(1048576);

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        CFG_SEGMENT_COUNT = 1'b0,
        CFG_SEGMENT_SIZE  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_op                  op;
        logic [LEN_BITS-1:0]  header_bytes;
        logic [LEN_BITS-1:0]  payload_bytes;
        logic [TYPE_BITS-1:0] packet_type;
        logic                 is_key;
        logic [SEQ_BITS-1:0]  lookup_sequence;
    } t_req;

    typedef struct packed {
        logic                   ok;
        logic [SEG_BITS-1:0]    segment;
        logic [OFFSET_BITS-1:0] offset;
        logic [LEN_BITS-1:0]    length;
        logic [TYPE_BITS-1:0]   type_out;
        logic [SEQ_BITS-1:0]    sequence_res;
        logic                   cover_valid;
        logic [SEQ_BITS-1:0]    cover_start;
        logic [SEQ_BITS-1:0]    cover_end;
        logic [SEQ_BITS-1:0]    key_sequence;
    } t_rsp;

    typedef struct packed {
        logic [SEG_BITS-1:0]    seg;
        logic [OFFSET_BITS-1:0] off;
        logic [LEN_BITS-1:0]    len;
        logic [TYPE_BITS-1:0]   ptype;
    } t_desc;

    localparam int DESC_BITS = $bits(t_desc);

    typedef struct packed {
        logic [CNT_BITS-1:0]  seg_count;
        logic [SIZE_BITS-1:0] seg_size;
    } t_cfg;

    // Second stage: push result is final, a pop waits for the descriptor read.
    typedef struct packed {
        logic valid;
        logic is_pop;
        logic found;
        t_rsp rsp;
    } t_stage;

endpackage

`default_nettype wire

### hw/rtl/srpa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srpa_req_if import srpa_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/srpa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srpa_rsp_if import srpa_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/srpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/srpa_alloc.sv
`timescale 1ns / 1ps
`default_nettype none

module srpa_alloc import srpa_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_a_valid,
    input  wire t_req   i_a,
    input  wire t_cfg   i_cfg,
    output t_stage      o_b,
    output t_desc       o_desc
);

    // Current segment is mirrored in registers; the arrays hold closed segments.
    logic [SEG_BITS-1:0]    r_cur;
    logic                   r_wrapped;
    logic [SEQ_BITS-1:0]    r_next_seq;
    logic [SEQ_BITS-1:0]    r_last_key;
    logic [SEQ_BITS-1:0]    r_oldest;
    logic [OFFSET_BITS-1:0] r_fill;
    logic                   r_cur_empty;
    logic [SEQ_BITS-1:0]    r_cur_first;
    logic                   r_seg_empty [MAX_SEGMENTS];
    logic [SEQ_BITS-1:0]    r_seg_first [MAX_SEGMENTS];
    logic [SEQ_BITS-1:0]    r_seg_last  [MAX_SEGMENTS];
    t_stage                 r_b;

    logic [CNT_BITS-1:0]    used;
    logic [LEN_BITS:0]      total;
    logic                   push_ok;
    logic                   need_move;
    logic [CNT_BITS-1:0]    next_idx;
    logic                   wrap_now;
    logic [SEG_BITS-1:0]    new_cur;
    logic                   new_wrapped;
    logic                   same_seg;
    logic                   src_empty;
    logic [SEQ_BITS-1:0]    src_first;
    logic [SEQ_BITS-1:0]    src_last;
    logic                   cover_hit;
    logic [SEG_BITS-1:0]    place_seg;
    logic [OFFSET_BITS-1:0] place_off;
    logic                   is_pop;
    logic                   do_push;
    logic [SEQ_BITS-1:0]    span;
    logic [SEQ_BITS-1:0]    age;
    logic                   hit;
    t_desc                  wdesc;
    t_stage                 n_b;

    always_comb begin
        if (i_cfg.seg_count == '0) begin
            used = CNT_BITS'(1);
        end else if (i_cfg.seg_count > CNT_BITS'(MAX_SEGMENTS)) begin
            used = CNT_BITS'(MAX_SEGMENTS);
        end else begin
            used = i_cfg.seg_count;
        end
    end

    assign total     = {1'b0, i_a.header_bytes} + {1'b0, i_a.payload_bytes};
    assign push_ok   = (i_a.payload_bytes != '0) && (total <= {1'b0, i_cfg.seg_size});
    assign need_move = ({1'b0, r_fill} + total) > {1'b0, i_cfg.seg_size};

    assign next_idx    = {1'b0, r_cur} + CNT_BITS'(1);
    assign wrap_now    = next_idx >= used;
    assign new_cur     = wrap_now ? '0 : next_idx[SEG_BITS-1:0];
    assign new_wrapped = r_wrapped | wrap_now;
    assign same_seg    = new_cur == r_cur;

    // A single-segment ring re-enters the segment it is leaving.
    assign src_empty = same_seg ? r_cur_empty : r_seg_empty[new_cur];
    assign src_first = same_seg ? r_cur_first : r_seg_first[new_cur];
    assign src_last  = same_seg ? (r_next_seq - SEQ_BITS'(1)) : r_seg_last[new_cur];
    assign cover_hit = need_move && new_wrapped && !src_empty;

    assign place_seg = need_move ? new_cur : r_cur;
    assign place_off = need_move ? '0 : r_fill;

    assign is_pop  = i_a.op == OP_POP;
    assign do_push = i_en && i_a_valid && !is_pop && push_ok;

    assign span = r_next_seq - r_oldest;
    assign age  = r_next_seq - i_a.lookup_sequence;
    assign hit  = ((i_a.lookup_sequence - r_oldest) < span) && (age != '0)
                  && (age <= SEQ_BITS'(DESCRIPTOR_DEPTH));

    assign wdesc.seg   = place_seg;
    assign wdesc.off   = place_off;
    assign wdesc.len   = total[LEN_BITS-1:0];
    assign wdesc.ptype = i_a.packet_type;

    always_comb begin
        n_b        = '0;
        n_b.valid  = i_a_valid;
        n_b.is_pop = is_pop;
        n_b.found  = hit;
        n_b.rsp.key_sequence = r_last_key;
        if (!is_pop && push_ok) begin
            n_b.rsp.ok           = 1'b1;
            n_b.rsp.segment      = place_seg;
            n_b.rsp.offset       = place_off;
            n_b.rsp.length       = total[LEN_BITS-1:0];
            n_b.rsp.sequence_res = r_next_seq;
            n_b.rsp.cover_valid  = cover_hit;
            n_b.rsp.cover_start  = cover_hit ? src_first : '0;
            n_b.rsp.cover_end    = cover_hit ? src_last : '0;
            if (i_a.is_key) begin
                n_b.rsp.key_sequence = r_next_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_wrapped   <= 1'b0;
            r_next_seq  <= '0;
            r_last_key  <= '0;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_cur_empty <= 1'b1;
            for (int i = 0; i < MAX_SEGMENTS; i++) begin
                r_seg_empty[i] <= 1'b1;
            end
            r_b.valid   <= 1'b0;
        end else begin
            if (i_en) begin
                r_b <= n_b;
            end
            if (do_push) begin
                if (need_move) begin
                    // close the segment being left
                    r_seg_empty[r_cur] <= r_cur_empty;
                    r_seg_first[r_cur] <= r_cur_first;
                    r_seg_last[r_cur]  <= r_next_seq - SEQ_BITS'(1);
                    r_cur              <= new_cur;
                    r_wrapped          <= new_wrapped;
                    if (cover_hit) begin
                        r_oldest <= src_last + SEQ_BITS'(1);
                    end
                end
                if (need_move || r_cur_empty) begin
                    r_cur_first <= r_next_seq;
                end
                r_cur_empty <= 1'b0;
                r_fill      <= place_off + total[OFFSET_BITS-1:0];
                if (i_a.is_key) begin
                    r_last_key <= r_next_seq;
                end
                r_next_seq  <= r_next_seq + SEQ_BITS'(1);
            end
        end
    end

    srpa_ram #(
        .WIDTH (DESC_BITS),
        .DEPTH (DESCRIPTOR_DEPTH)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_next_seq[DESC_ADDR_BITS-1:0]),
        .i_wdata (wdesc),
        .i_re    (i_en && i_a_valid && is_pop),
        .i_raddr (i_a.lookup_sequence[DESC_ADDR_BITS-1:0]),
        .o_rdata (o_desc)
    );

    assign o_b = r_b;

endmodule

`default_nettype wire

### hw/rtl/segmented_ring_packet_allocator.sv
// Pipeline: input register, second stage, result register; one request per cycle
//   unless the result stalls. The descriptor memory takes one write or one read per
//   cycle, and the ring state updates as a request enters the second stage.
// Reset (synchronous, active low) empties the pipeline and the ring, clears the
//   sequence counters and restores segment_count 16 and segment_size 1048576.
`timescale 1ns / 1ps
`default_nettype none

module segmented_ring_packet_allocator import srpa_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire t_cfg_index               i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    srpa_req_if.sink                      i_req,
    srpa_rsp_if.source                    o_rsp
);

    t_cfg   r_cfg;
    logic   r_a_valid;
    t_req   r_a;
    logic   r_out_valid;
    t_rsp   r_out;
    t_rsp   n_out;
    logic   en;
    t_stage b;
    t_desc  desc;

    // Advance the whole pipeline unless the result register is held.
    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_count <= SEG_COUNT_RESET;
            r_cfg.seg_size  <= SEG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEGMENT_COUNT: r_cfg.seg_count <= i_cfg_data[CNT_BITS-1:0];
                CFG_SEGMENT_SIZE:  r_cfg.seg_size  <= i_cfg_data[SIZE_BITS-1:0];
                default:           r_cfg           <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_req.valid;
            r_a       <= i_req.data;
        end
    end

    srpa_alloc u_alloc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_a_valid (r_a_valid),
        .i_a       (r_a),
        .i_cfg     (r_cfg),
        .o_b       (b),
        .o_desc    (desc)
    );

    always_comb begin
        n_out = b.rsp;
        if (b.is_pop && b.found) begin
            n_out.ok       = 1'b1;
            n_out.segment  = desc.seg;
            n_out.offset   = desc.off;
            n_out.length   = desc.len;
            n_out.type_out = desc.ptype;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= b.valid;
            r_out       <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

### hw/rtl/srpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "segmented_ring_packet_allocator_macros.svh"

module srpa_checker import srpa_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire t_rsp i_out_data
);

    `SRPA_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    `SRPA_ASSERT_IMPLIES(a_hold_stalled, i_clk, i_rst_n, $past(i_out_valid && !i_out_ready) && $past(i_rst_n), i_out_valid && $stable(i_out_data), "stalled result changed")

    `SRPA_ASSERT_IMPLIES(a_reject_zero, i_clk, i_rst_n, i_out_valid && !i_out_data.ok, i_out_data.segment == '0 && i_out_data.offset == '0 && i_out_data.length == '0 && i_out_data.sequence_res == '0 && !i_out_data.cover_valid, "failed request carries placement")

    `SRPA_ASSERT_IMPLIES(a_ok_length, i_clk, i_rst_n, i_out_valid && i_out_data.ok, i_out_data.length != '0, "placed packet has zero length")

endmodule

bind segmented_ring_packet_allocator srpa_checker u_srpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);

`default_nettype wire
